// ----- sv/bsig_pkg.sv -----
// Package for the byte stream integrity guard.
// Holds the request and status codes and the fixed metric constants.
// No dependencies.
package bsig_pkg;

  typedef logic [1:0]  req_t;
  typedef logic [1:0]  status_t;
  typedef logic [63:0] metric_t;

  localparam req_t REQ_DATA     = 2'd0;
  localparam req_t REQ_EMPTY    = 2'd1;
  localparam req_t REQ_SAVE     = 2'd2;
  localparam req_t REQ_ROLLBACK = 2'd3;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_BOUND      = 2'd1;
  localparam status_t ST_WD_EXPIRED = 2'd2;
  localparam status_t ST_WD_BROKEN  = 2'd3;

  localparam metric_t     GOLDEN64      = 64'h9e37_79b9_7f4a_7c15;
  localparam metric_t     ENTROPY_BOUND = 64'h0010_0000_0000_0000;
  localparam logic [31:0] DEFAULT_LIMIT = 32'd32;
  localparam logic [31:0] SAT32         = 32'hffff_ffff;
  localparam int unsigned HASH_ROT      = 13;

endpackage

// ----- sv/byte_stream_integrity_guard.sv -----
// Byte stream integrity guard: scans buffers byte by byte and keeps four metrics
// under bound and watchdog checks with checkpoint and rollback.
// Depends on bsig_pkg.

// Items pass through an input register and are processed from there, which
// updates the scan state and metrics and loads the result register; one item
// is taken every cycle unless the input side stalls, so throughput is one item
// per clock while not stalled. Only items that end a buffer (an empty
// step, or a data byte flagged last) produce a result; checkpoint and forced
// rollback items produce none. While a result sits unread in the output register,
// items that produce no result keep flowing, and the input side stalls only when
// a second result is ready behind it. The watchdog limit may be written at any
// idle time; zero acts as 32.
module byte_stream_integrity_guard
  import bsig_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_cycle_sum,
  output logic [63:0] out_connectivity,
  output logic [63:0] out_entropy,
  output logic [63:0] out_mixed_hash,
  output logic [31:0] out_rollbacks,
  output logic        out_failsafe
);

  // configuration
  logic [31:0] wd_limit_r;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  req_t        s1_req_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // scan state
  logic [7:0]  prev_byte_r, prev_byte_nxt;
  logic [31:0] byte_pos_r, byte_pos_nxt;
  logic [31:0] trans_cnt_r, trans_cnt_nxt;
  logic [63:0] fold_r, fold_nxt;

  // metrics and watchdog
  metric_t     cyc_r, cyc_nxt, conn_r, conn_nxt, ent_r, ent_nxt, hash_r, hash_nxt;
  metric_t     sv_cyc_r, sv_conn_r, sv_ent_r, sv_hash_r;
  logic        save_en;
  logic [31:0] wd_cnt_r, wd_cnt_nxt, wd_mirror_r, wd_mirror_nxt;
  logic [31:0] rb_total_r, rb_total_nxt;
  logic        failsafe_r, failsafe_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, status_nxt;
  metric_t     out_cyc_r, out_conn_r, out_ent_r, out_hash_r;
  logic [31:0] out_rb_r;
  logic        out_fs_r;

  // processing stage
  logic        s2_has_result, s2_go;
  logic        is_data, is_end;
  logic [7:0]  b_prev;
  logic [31:0] t_after;
  logic [63:0] f_after;
  logic [63:0] t64;
  logic [31:0] limit_eff;
  metric_t     c_cyc, c_conn, c_ent, c_hash, mixed;
  logic        do_rb;

  assign is_data       = (s1_req_r == REQ_DATA);
  assign s2_has_result = (s1_req_r == REQ_EMPTY) || (is_data && s1_last_r);
  assign s2_go         = s1_valid_r && (!s2_has_result || !out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s2_go;
  assign is_end        = s2_go && s2_has_result;
  assign limit_eff     = (wd_limit_r == 32'd0) ? DEFAULT_LIMIT : wd_limit_r;
  assign b_prev        = prev_byte_r;

  // byte scan: what the state looks like after this item's byte
  always_comb begin
    t_after = trans_cnt_r;
    f_after = fold_r;
    if (is_data) begin
      if (byte_pos_r != 32'd0 && s1_byte_r != b_prev && trans_cnt_r != SAT32) begin
        t_after = trans_cnt_r + 32'd1;
      end
      // saturated positions keep folding into lane 7
      f_after = fold_r ^ ({56'd0, s1_byte_r} << {byte_pos_r[2:0], 3'b000});
    end
  end

  assign t64   = {32'd0, t_after};
  assign mixed = hash_r ^ f_after ^ t64;
  assign c_cyc  = cyc_r + {58'd0, t_after[5:0]};
  assign c_conn = ({conn_r[62:0], 1'b0} + conn_r + t64 + 64'd1) >> 1;
  assign c_ent  = ent_r + {56'd0, f_after[7:0]} + t64;
  assign c_hash = {mixed[63-HASH_ROT:0], mixed[63:64-HASH_ROT]} + GOLDEN64;

  always_comb begin
    prev_byte_nxt = prev_byte_r;
    byte_pos_nxt  = byte_pos_r;
    trans_cnt_nxt = trans_cnt_r;
    fold_nxt      = fold_r;
    cyc_nxt       = cyc_r;
    conn_nxt      = conn_r;
    ent_nxt       = ent_r;
    hash_nxt      = hash_r;
    wd_cnt_nxt    = wd_cnt_r;
    wd_mirror_nxt = wd_mirror_r;
    status_nxt    = ST_OK;
    do_rb         = 1'b0;
    save_en       = 1'b0;
    if (s2_go) begin
      case (s1_req_r)
        REQ_SAVE: begin
          save_en = 1'b1;
        end
        REQ_ROLLBACK: begin
          do_rb = 1'b1;
        end
        default: begin
          if (is_data) begin
            prev_byte_nxt = s1_byte_r;
            byte_pos_nxt  = (byte_pos_r == SAT32) ? byte_pos_r : byte_pos_r + 32'd1;
            trans_cnt_nxt = t_after;
            fold_nxt      = f_after;
          end
          if (is_end) begin
            prev_byte_nxt = 8'd0;
            byte_pos_nxt  = 32'd0;
            trans_cnt_nxt = 32'd0;
            fold_nxt      = 64'd0;
            if (wd_mirror_r != ~wd_cnt_r) begin
              do_rb      = 1'b1;
              status_nxt = ST_WD_BROKEN;
            end else begin
              cyc_nxt  = c_cyc;
              conn_nxt = c_conn;
              ent_nxt  = c_ent;
              hash_nxt = c_hash;
              if (c_conn == 64'd0 || c_ent > ENTROPY_BOUND) begin
                do_rb      = 1'b1;
                status_nxt = ST_BOUND;
              end else begin
                // freshly rewritten pair is coherent; only the limit can trip
                wd_cnt_nxt    = wd_cnt_r + 32'd1;
                wd_mirror_nxt = ~(wd_cnt_r + 32'd1);
                if ((wd_cnt_r + 32'd1) >= limit_eff) begin
                  do_rb      = 1'b1;
                  status_nxt = ST_WD_EXPIRED;
                end
              end
            end
          end
        end
      endcase
    end
    rb_total_nxt = rb_total_r;
    failsafe_nxt = failsafe_r;
    if (do_rb) begin
      cyc_nxt       = sv_cyc_r;
      conn_nxt      = sv_conn_r;
      ent_nxt       = sv_ent_r;
      hash_nxt      = sv_hash_r;
      rb_total_nxt  = rb_total_r + 32'd1;
      failsafe_nxt  = 1'b1;
      wd_cnt_nxt    = 32'd0;
      wd_mirror_nxt = SAT32;
    end
  end

  assign s1_valid_nxt  = (in_valid && !in_stall) ? 1'b1 : (s1_valid_r && !s2_go);
  assign out_valid_nxt = is_end ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_limit_r  <= DEFAULT_LIMIT;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_byte_r <= 8'd0;
      byte_pos_r  <= 32'd0;
      trans_cnt_r <= 32'd0;
      fold_r      <= 64'd0;
      cyc_r       <= 64'd0;
      conn_r      <= 64'd0;
      ent_r       <= 64'd0;
      hash_r      <= 64'd0;
      sv_cyc_r    <= 64'd0;
      sv_conn_r   <= 64'd0;
      sv_ent_r    <= 64'd0;
      sv_hash_r   <= 64'd0;
      wd_cnt_r    <= 32'd0;
      wd_mirror_r <= SAT32;
      rb_total_r  <= 32'd0;
      failsafe_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wd_limit_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      prev_byte_r <= prev_byte_nxt;
      byte_pos_r  <= byte_pos_nxt;
      trans_cnt_r <= trans_cnt_nxt;
      fold_r      <= fold_nxt;
      cyc_r       <= cyc_nxt;
      conn_r      <= conn_nxt;
      ent_r       <= ent_nxt;
      hash_r      <= hash_nxt;
      if (save_en) begin
        sv_cyc_r  <= cyc_r;
        sv_conn_r <= conn_r;
        sv_ent_r  <= ent_r;
        sv_hash_r <= hash_r;
      end
      wd_cnt_r    <= wd_cnt_nxt;
      wd_mirror_r <= wd_mirror_nxt;
      rb_total_r  <= rb_total_nxt;
      failsafe_r  <= failsafe_nxt;
    end
  end

  // payload registers: the input ones load on acceptance, the output ones when a result is produced; hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (is_end) begin
      out_status_r <= status_nxt;
      out_cyc_r    <= cyc_nxt;
      out_conn_r   <= conn_nxt;
      out_ent_r    <= ent_nxt;
      out_hash_r   <= hash_nxt;
      out_rb_r     <= rb_total_nxt;
      out_fs_r     <= failsafe_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_cycle_sum    = out_cyc_r;
  assign out_connectivity = out_conn_r;
  assign out_entropy      = out_ent_r;
  assign out_mixed_hash   = out_hash_r;
  assign out_rollbacks    = out_rb_r;
  assign out_failsafe     = out_fs_r;

  a_wd_pair_coherent: assert property (@(posedge clk) disable iff (!rst_n)
    wd_mirror_r == ~wd_cnt_r)
    else $error("watchdog mirror lost its complement");

  a_failsafe_tracks_rollbacks: assert property (@(posedge clk) disable iff (!rst_n)
    !failsafe_r |-> rb_total_r == 32'd0)
    else $error("rollbacks counted without failsafe set");

  a_rollback_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (rb_total_r == $past(rb_total_r) || rb_total_r == $past(rb_total_r) + 32'd1))
    else $error("rollback count jumped");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !is_end)
    else $error("pending result overwritten");

endmodule
